>>> hw/rtl/kct_pkg.sv
// kct_pkg: types, constants and saturating helpers for the tracker.
// No dependencies.
package kct_pkg;
   localparam int DataWidth = 32;
   localparam int FracBits  = 16;
   localparam int CfgWidth  = 31;
   localparam int CsrIdxWidth = 2;

   localparam logic [CsrIdxWidth-1:0] CsrQPos  = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrQVel  = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrRNoise = 2'd2;

   localparam logic signed [DataWidth-1:0] One = DataWidth'(1) <<< FracBits;
   localparam logic signed [DataWidth-1:0] VMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] VMin = {1'b1, {(DataWidth-1){1'b0}}};

   // sequencer steps
   typedef enum logic [4:0] {
      ST_IDLE, ST_M_PRED, ST_A_PRED, ST_M_DTVV, ST_A_PPV, ST_A_PVP, ST_A_PVV,
      ST_M_DTVP, ST_A_PPP1, ST_M_DTPPV, ST_A_PPP2, ST_A_PPP3, ST_A_S,
      ST_DIV_KP, ST_DIV_KV, ST_A_E, ST_M_KPE, ST_A_POS, ST_M_KVE, ST_A_VEL,
      ST_A_OMK, ST_M_CPP, ST_M_CPV, ST_M_KVPP, ST_A_CVP, ST_M_KVPV, ST_A_CVV,
      ST_RESET, ST_OUT
   } kct_state_type;

   // multiplier/adder operand selects
   typedef enum logic [4:0] {
      OP_POS, OP_VEL, OP_PP, OP_PV, OP_VP, OP_VV, OP_DT, OP_T0, OP_T1,
      OP_KP, OP_KV, OP_E, OP_QP, OP_QV, OP_RN, OP_ONE, OP_Z
   } kct_opnd_type;

   typedef enum logic [3:0] {
      DS_NONE, DS_POS, DS_VEL, DS_PP, DS_PV, DS_VP, DS_VV, DS_T0, DS_T1,
      DS_KP, DS_KV, DS_E, DS_S
   } kct_dst_type;

   typedef enum logic [1:0] {
      FN_ADD, FN_SUB, FN_MUL
   } kct_fn_type;

   typedef struct packed {
      logic          load;      // latch a new item
      logic          rst_est;   // restore estimate and covariance
      logic          alu_en;
      kct_fn_type    fn;
      kct_opnd_type  opa;
      kct_opnd_type  opb;
      kct_dst_type   dst;
      logic          div_start;
      kct_opnd_type  div_num;
      kct_dst_type   div_dst;
   } kct_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic s_zero;
   } kct_sts_type;

   function automatic logic signed [DataWidth-1:0] sat_add(
      input logic signed [DataWidth-1:0] a, input logic signed [DataWidth-1:0] b,
      input logic sub);
      logic signed [DataWidth:0] s;
      begin
         s = sub ? ({a[DataWidth-1], a} - {b[DataWidth-1], b})
                 : ({a[DataWidth-1], a} + {b[DataWidth-1], b});
         if (s[DataWidth] != s[DataWidth-1])
            sat_add = s[DataWidth] ? VMin : VMax;
         else
            sat_add = s[DataWidth-1:0];
      end
   endfunction

   // apply sign to magnitude, saturating
   function automatic logic signed [DataWidth-1:0] sign_sat(
      input logic [2*DataWidth-1:0] m, input logic neg);
      logic [2*DataWidth-1:0] lim;
      begin
         lim = neg ? (2*DataWidth)'(VMax) + 1'b1 : (2*DataWidth)'(VMax);
         if (m >= lim)
            sign_sat = neg ? VMin : VMax;
         else
            sign_sat = neg ? -DataWidth'(m) : DataWidth'(m);
      end
   endfunction
endpackage

>>> hw/rtl/kct_datapath.sv
// kct_datapath: register file, one shared saturating ALU with a multiplier
// and a radix-2 divider. Depends on kct_pkg.
module kct_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  kct_pkg::kct_cmd_type            cmd,
   output kct_pkg::kct_sts_type            sts,
   input  logic signed [kct_pkg::DataWidth-1:0] req_measurement,
   input  logic [kct_pkg::CfgWidth-1:0]    req_time_step,
   input  logic                            csr_write,
   input  logic [kct_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [kct_pkg::CfgWidth-1:0]    csr_data,
   output logic signed [kct_pkg::DataWidth-1:0] pos_out,
   output logic signed [kct_pkg::DataWidth-1:0] vel_out
);
   import kct_pkg::*;

   localparam int DW = DataWidth;
   localparam int QW = DW + FracBits;     // quotient bits
   localparam int CW = $clog2(QW + 1);

   logic [CfgWidth-1:0] qp_ff, qv_ff, rn_ff;
   logic signed [DW-1:0] pos_ff, vel_ff, pp_ff, pv_ff, vp_ff, vv_ff;
   logic signed [DW-1:0] z_ff, dt_ff, t0_ff, t1_ff, kp_ff, kv_ff, e_ff, s_ff;
   logic signed [DW-1:0] res, a_val, b_val;
   logic signed [DW-1:0] pos_in, vel_in, pp_in, pv_in, vp_in, vv_in;

   // multiplier pipeline
   logic [2*DW-1:0] prod_ff;
   logic            mneg_ff, mbusy_ff, mdone_ff;
   logic [DW-1:0]   ma, mb;

   // divider
   logic [QW-1:0]   dq_ff;
   logic [DW:0]     drem_ff;
   logic [DW-1:0]   dden_ff;
   logic [2*DW-1:0] dnum_ff;
   logic [CW-1:0]   dcnt_ff;
   logic            dbusy_ff, ddone_ff, dneg_ff;
   kct_dst_type     ddst_ff;
   logic [DW:0]     dtrial;
   logic signed [DW-1:0] dres, dnum_sel;

   function automatic logic signed [DW-1:0] pick(input kct_opnd_type o,
      input logic signed [DW-1:0] pos, vel, pp, pv, vp, vv, dt, t0, t1,
      kp, kv, e, z, qp, qv, rn);
      begin
         unique case (o)
            OP_POS: pick = pos;
            OP_VEL: pick = vel;
            OP_PP:  pick = pp;
            OP_PV:  pick = pv;
            OP_VP:  pick = vp;
            OP_VV:  pick = vv;
            OP_DT:  pick = dt;
            OP_T0:  pick = t0;
            OP_T1:  pick = t1;
            OP_KP:  pick = kp;
            OP_KV:  pick = kv;
            OP_E:   pick = e;
            OP_Z:   pick = z;
            OP_QP:  pick = qp;
            OP_QV:  pick = qv;
            OP_RN:  pick = rn;
            default: pick = One;
         endcase
      end
   endfunction

   logic signed [DW-1:0] rn_eff;
   assign rn_eff = (rn_ff == '0) ? DW'(1) : DW'(rn_ff);

   always_comb begin
      a_val = pick(cmd.opa, pos_ff, vel_ff, pp_ff, pv_ff, vp_ff, vv_ff, dt_ff, t0_ff,
                   t1_ff, kp_ff, kv_ff, e_ff, z_ff, DW'(qp_ff), DW'(qv_ff), rn_eff);
      b_val = pick(cmd.opb, pos_ff, vel_ff, pp_ff, pv_ff, vp_ff, vv_ff, dt_ff, t0_ff,
                   t1_ff, kp_ff, kv_ff, e_ff, z_ff, DW'(qp_ff), DW'(qv_ff), rn_eff);
      dnum_sel = pick(cmd.div_num, pos_ff, vel_ff, pp_ff, pv_ff, vp_ff, vv_ff, dt_ff,
                      t0_ff, t1_ff, kp_ff, kv_ff, e_ff, z_ff, DW'(qp_ff), DW'(qv_ff),
                      rn_eff);
      ma = a_val[DW-1] ? DW'(-a_val) : DW'(a_val);
      mb = b_val[DW-1] ? DW'(-b_val) : DW'(b_val);
   end

   // ALU result: product is taken from the registered multiplier output
   logic [2*DW-1:0] shifted;
   assign shifted = prod_ff >> FracBits;
   always_comb begin
      unique case (cmd.fn)
         FN_ADD:  res = sat_add(a_val, b_val, 1'b0);
         FN_SUB:  res = sat_add(a_val, b_val, 1'b1);
         default: res = sign_sat(shifted, mneg_ff);
      endcase
   end

   // multiplier: registers the product and sets busy, then raises done from busy
   always_ff @(posedge clock) begin
      if (reset) begin
         mbusy_ff <= 1'b0;
         mdone_ff <= 1'b0;
      end else begin
         mdone_ff <= 1'b0;
         if (cmd.alu_en && cmd.fn == FN_MUL && !mbusy_ff && !mdone_ff) begin
            mbusy_ff <= 1'b1;
         end else if (mbusy_ff) begin
            mbusy_ff <= 1'b0;
            mdone_ff <= 1'b1;
         end
      end
      if (cmd.alu_en && cmd.fn == FN_MUL && !mbusy_ff && !mdone_ff) begin
         prod_ff <= ma * mb;
         mneg_ff <= a_val[DW-1] ^ b_val[DW-1];
      end
   end

   // restoring divider: |num|<<FracBits / |den|, one quotient bit a cycle
   assign dtrial = {drem_ff[DW-1:0], dnum_ff[2*DW-1]} - {1'b0, dden_ff};
   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.div_start && !dbusy_ff && !ddone_ff) begin
            dbusy_ff <= 1'b1;
         end else if (dbusy_ff && dcnt_ff == CW'(QW - 1)) begin
            dbusy_ff <= 1'b0;
            ddone_ff <= 1'b1;
         end
      end
      // magnitude sits in the upper half so the 48 bits shifted out are num<<FracBits
      if (cmd.div_start && !dbusy_ff && !ddone_ff) begin
         dnum_ff <= (2*DW)'(dnum_sel[DW-1] ? DW'(-dnum_sel) : DW'(dnum_sel)) << DW;
         dden_ff <= s_ff[DW-1] ? DW'(-s_ff) : DW'(s_ff);
         dneg_ff <= dnum_sel[DW-1] ^ s_ff[DW-1];
         drem_ff <= '0;
         dq_ff   <= '0;
         dcnt_ff <= '0;
         ddst_ff <= cmd.div_dst;
      end else if (dbusy_ff) begin
         dnum_ff <= dnum_ff << 1;
         dcnt_ff <= dcnt_ff + 1'b1;
         if (!dtrial[DW]) begin
            drem_ff <= dtrial;
            dq_ff   <= {dq_ff[QW-2:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[DW-1:0], dnum_ff[2*DW-1]};
            dq_ff   <= {dq_ff[QW-2:0], 1'b0};
         end
      end
   end
   assign dres = sign_sat((2*DW)'(dq_ff), dneg_ff);

   assign sts.mul_done = mdone_ff;
   assign sts.div_done = ddone_ff;
   assign sts.s_zero   = (s_ff == '0);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff <= CfgWidth'(66);
         qv_ff <= CfgWidth'(655);
         rn_ff <= CfgWidth'(32768);
      end else if (csr_write) begin
         unique case (csr_index)
            CsrQPos:   qp_ff <= csr_data;
            CsrQVel:   qv_ff <= csr_data;
            CsrRNoise: rn_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // write-back of the state registers
   logic wr;
   assign wr = cmd.alu_en && (cmd.fn != FN_MUL || mdone_ff);
   always_comb begin
      pos_in = pos_ff; vel_in = vel_ff; pp_in = pp_ff;
      pv_in = pv_ff;   vp_in = vp_ff;   vv_in = vv_ff;
      if (cmd.rst_est) begin
         pos_in = '0; vel_in = '0; pp_in = One; pv_in = '0; vp_in = '0; vv_in = One;
      end else if (wr) begin
         unique case (cmd.dst)
            DS_POS: pos_in = res;
            DS_VEL: vel_in = res;
            DS_PP:  pp_in  = res;
            DS_PV:  pv_in  = res;
            DS_VP:  vp_in  = res;
            DS_VV:  vv_in  = res;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; vel_ff <= '0; pp_ff <= One;
         pv_ff <= '0;  vp_ff <= '0;  vv_ff <= One;
      end else begin
         pos_ff <= pos_in; vel_ff <= vel_in; pp_ff <= pp_in;
         pv_ff <= pv_in;   vp_ff <= vp_in;   vv_ff <= vv_in;
      end
   end

   // scratch registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         z_ff  <= req_measurement;
         dt_ff <= DW'(req_time_step);
         kp_ff <= '0;
         kv_ff <= '0;
      end
      if (wr) begin
         unique case (cmd.dst)
            DS_T0: t0_ff <= res;
            DS_T1: t1_ff <= res;
            DS_E:  e_ff  <= res;
            DS_S:  s_ff  <= res;
            default: ;
         endcase
      end
      if (ddone_ff) begin
         if (ddst_ff == DS_KP) kp_ff <= dres;
         else                  kv_ff <= dres;
      end
   end

   assign pos_out = pos_ff;
   assign vel_out = vel_ff;
endmodule

>>> hw/rtl/kct_control.sv
// kct_control: sequencer that steps the shared datapath through one
// predict/correct pass. Depends on kct_pkg.
module kct_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output kct_pkg::kct_cmd_type cmd,
   input  kct_pkg::kct_sts_type sts
);
   import kct_pkg::*;

   kct_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // at most one ALU step per state; multiply states wait for the product, divide states for the quotient
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '{load: 1'b0, rst_est: 1'b0, alu_en: 1'b0, fn: FN_ADD,
                    opa: OP_ONE, opb: OP_ONE, dst: DS_NONE, div_start: 1'b0,
                    div_num: OP_PP, div_dst: DS_KP};
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = req_opcode ? ST_RESET : ST_M_PRED;
            end
         end
         ST_RESET: begin
            cmd.rst_est = 1'b1;
            state_in = ST_OUT;
         end
         ST_M_PRED: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_VEL; cmd.opb = OP_DT;
            cmd.dst = DS_T0;
            if (sts.mul_done) state_in = ST_A_PRED;
         end
         ST_A_PRED: begin   // t0 = predicted position
            cmd.alu_en = 1'b1; cmd.opa = OP_POS; cmd.opb = OP_T0; cmd.dst = DS_T0;
            state_in = ST_M_DTVV;
         end
         ST_M_DTVV: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_DT; cmd.opb = OP_VV;
            cmd.dst = DS_T1;
            if (sts.mul_done) state_in = ST_M_DTVP;
         end
         ST_M_DTVP: begin   // e holds dt*Pvp temporarily
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_DT; cmd.opb = OP_VP;
            cmd.dst = DS_E;
            if (sts.mul_done) state_in = ST_A_PPP1;
         end
         ST_A_PPP1: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_PP; cmd.opb = OP_E; cmd.dst = DS_PP;
            state_in = ST_A_PPV;
         end
         ST_A_PPV: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_PV; cmd.opb = OP_T1; cmd.dst = DS_PV;
            state_in = ST_A_PVP;
         end
         ST_A_PVP: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_VP; cmd.opb = OP_T1; cmd.dst = DS_VP;
            state_in = ST_A_PVV;
         end
         ST_A_PVV: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_VV; cmd.opb = OP_QV; cmd.dst = DS_VV;
            state_in = ST_M_DTPPV;
         end
         ST_M_DTPPV: begin  // dt * predicted Ppv
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_DT; cmd.opb = OP_PV;
            cmd.dst = DS_E;
            if (sts.mul_done) state_in = ST_A_PPP2;
         end
         ST_A_PPP2: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_PP; cmd.opb = OP_E; cmd.dst = DS_PP;
            state_in = ST_A_PPP3;
         end
         ST_A_PPP3: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_PP; cmd.opb = OP_QP; cmd.dst = DS_PP;
            state_in = ST_A_S;
         end
         ST_A_S: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_PP; cmd.opb = OP_RN; cmd.dst = DS_S;
            state_in = ST_A_E;
         end
         ST_A_E: begin      // innovation: measurement less predicted position
            cmd.alu_en = 1'b1; cmd.fn = FN_SUB; cmd.opa = OP_Z; cmd.opb = OP_T0;
            cmd.dst = DS_E;
            state_in = sts.s_zero ? ST_M_KPE : ST_DIV_KP;
         end
         ST_DIV_KP: begin
            cmd.div_start = 1'b1; cmd.div_num = OP_PP; cmd.div_dst = DS_KP;
            if (sts.div_done) state_in = ST_DIV_KV;
         end
         ST_DIV_KV: begin
            cmd.div_start = 1'b1; cmd.div_num = OP_VP; cmd.div_dst = DS_KV;
            if (sts.div_done) state_in = ST_M_KPE;
         end
         ST_M_KPE: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_KP; cmd.opb = OP_E;
            cmd.dst = DS_T1;
            if (sts.mul_done) state_in = ST_A_POS;
         end
         ST_A_POS: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_T0; cmd.opb = OP_T1; cmd.dst = DS_POS;
            state_in = ST_M_KVE;
         end
         ST_M_KVE: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_KV; cmd.opb = OP_E;
            cmd.dst = DS_T1;
            if (sts.mul_done) state_in = ST_A_VEL;
         end
         ST_A_VEL: begin
            cmd.alu_en = 1'b1; cmd.opa = OP_VEL; cmd.opb = OP_T1; cmd.dst = DS_VEL;
            state_in = ST_A_OMK;
         end
         ST_A_OMK: begin    // t0 = 1 - Kp
            cmd.alu_en = 1'b1; cmd.fn = FN_SUB; cmd.opa = OP_ONE; cmd.opb = OP_KP;
            cmd.dst = DS_T0;
            state_in = ST_M_KVPP;
         end
         ST_M_KVPP: begin   // t1 = Kv * Ppp'
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_KV; cmd.opb = OP_PP;
            cmd.dst = DS_T1;
            if (sts.mul_done) state_in = ST_A_CVP;
         end
         ST_A_CVP: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_SUB; cmd.opa = OP_VP; cmd.opb = OP_T1;
            cmd.dst = DS_VP;
            state_in = ST_M_KVPV;
         end
         ST_M_KVPV: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_KV; cmd.opb = OP_PV;
            cmd.dst = DS_T1;
            if (sts.mul_done) state_in = ST_A_CVV;
         end
         ST_A_CVV: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_SUB; cmd.opa = OP_VV; cmd.opb = OP_T1;
            cmd.dst = DS_VV;
            state_in = ST_M_CPP;
         end
         ST_M_CPP: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_PP; cmd.opb = OP_T0;
            cmd.dst = DS_PP;
            if (sts.mul_done) state_in = ST_M_CPV;
         end
         ST_M_CPV: begin
            cmd.alu_en = 1'b1; cmd.fn = FN_MUL; cmd.opa = OP_PV; cmd.opb = OP_T0;
            cmd.dst = DS_PV;
            if (sts.mul_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

>>> hw/rtl/kalman_cv_tracker.sv
// kalman_cv_tracker: top level, joins sequencer and datapath.
// Depends on kct_pkg, kct_control, kct_datapath.
//
// One-dimensional constant-velocity Kalman tracker in signed Q16.16. One
// request is handled at a time: an update runs ten products on one shared
// multiplier, two 48-bit quotients on a radix-2 divider and fourteen adds
// before its result is offered; when the innovation variance is zero the
// quotients are skipped. A reset request restores the estimate and
// covariance in ST_RESET before its result is offered. The result is
// held on rsp_* until taken. The csr_ port may be written only while the
// block is idle; a written zero measurement noise acts as the smallest step.
module kalman_cv_tracker
   import kct_pkg::*;
(
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_opcode,
   input  logic signed [DataWidth-1:0]     req_measurement,
   input  logic [CfgWidth-1:0]             req_time_step,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [DataWidth-1:0]     rsp_position_est,
   output logic signed [DataWidth-1:0]     rsp_velocity_est,
   input  logic                            csr_write,
   input  logic [CsrIdxWidth-1:0]          csr_index,
   input  logic [CfgWidth-1:0]             csr_data
);
   kct_cmd_type cmd;
   kct_sts_type sts;

   kct_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .req_opcode,
      .rsp_valid, .rsp_ready, .cmd, .sts
   );

   kct_datapath u_dp (
      .clock, .reset, .cmd, .sts, .req_measurement, .req_time_step,
      .csr_write, .csr_index, .csr_data,
      .pos_out(rsp_position_est), .vel_out(rsp_velocity_est)
   );
endmodule

>>> hw/rtl/kct_checker.sv
// kct_checker: port-level checks on the tracker, bound to the top level.
// Depends on kalman_cv_tracker.
module kct_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_position_est,
   input logic [31:0] rsp_velocity_est
);
   // no new request while a result waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while result pending");

   // a reset request gives a zero estimate
   a_reset_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_opcode) |=> ##1
      (rsp_valid && rsp_position_est == '0 && rsp_velocity_est == '0))
      else $error("reset request result not zero");

   // result stays put while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_position_est)
      && $stable(rsp_velocity_est))) else $error("result changed under stall");

   // taken result frees the input side
   a_back_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> req_ready) else $error("not idle after result");
endmodule

bind kalman_cv_tracker kct_port_checks u_kct_port_checks (
   .clock, .reset, .req_valid, .req_ready, .req_opcode, .rsp_valid, .rsp_ready,
   .rsp_position_est, .rsp_velocity_est
);

>>> bench/kct_checker.sv
// kct_checker: watches the request, result and register ports of the tracker,
// predicts each estimate in Q16.16 and compares it with the block's output.
// Depends on kct_pkg for widths and register indexes.
module kct_checker
   import kct_pkg::*;
#(
   parameter logic ResetCode = 1'b1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic                        req_opcode,
   input  logic signed [DataWidth-1:0] req_measurement,
   input  logic [CfgWidth-1:0]         req_time_step,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic signed [DataWidth-1:0] rsp_position_est,
   input  logic signed [DataWidth-1:0] rsp_velocity_est,
   input  logic                        csr_write,
   input  logic [CsrIdxWidth-1:0]      csr_index,
   input  logic [CfgWidth-1:0]         csr_data,
   output int                          fail_count,
   output int                          pending,
   output int                          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint QMax = 64'sd2147483647;
   localparam longint QMin = -64'sd2147483648;
   localparam longint QOne = 64'sd65536;

   typedef struct {
      logic signed [DataWidth-1:0] pos;
      logic signed [DataWidth-1:0] vel;
   } estimate_t;

   estimate_t estimate_q[$];

   // filter state and register copies
   longint est_pos, est_vel, p_pp, p_pv, p_vp, p_vv;
   longint noise_qp, noise_qv, noise_r;

   function automatic longint clamp(input longint x);
      if (x > QMax) return QMax;
      if (x < QMin) return QMin;
      return x;
   endfunction

   function automatic longint signed_mag(input longint unsigned m, input bit neg);
      longint unsigned lim;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (m >= lim) return neg ? QMin : QMax;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // exact product, truncated toward zero
   function automatic longint qmul(input longint a, input longint b);
      longint unsigned ma, mb;
      ma = a < 0 ? longint'(-a) : a;
      mb = b < 0 ? longint'(-b) : b;
      return signed_mag((ma * mb) >> FracBits, (a < 0) != (b < 0));
   endfunction

   function automatic longint qdiv(input longint n, input longint d);
      longint unsigned mn, md;
      mn = n < 0 ? longint'(-n) : n;
      md = d < 0 ? longint'(-d) : d;
      return signed_mag((mn << FracBits) / md, (n < 0) != (d < 0));
   endfunction

   task automatic restore_estimate();
      est_pos = 0; est_vel = 0;
      p_pp = QOne; p_pv = 0; p_vp = 0; p_vv = QOne;
   endtask

   // one filter step over the accepted request
   task automatic filter_step(input logic op, input longint z, input longint dt);
      longint ppos, pvel, ppp, ppv, pvp, pvv, s, kp, kv, e, omk, rn;
      estimate_t exp_est;
      if (op == ResetCode) begin
         restore_estimate();
      end else begin
         rn = noise_r == 0 ? 1 : noise_r;
         kp = 0; kv = 0;
         ppos = clamp(est_pos + qmul(est_vel, dt));
         pvel = est_vel;
         ppp = clamp(p_pp + qmul(dt, p_vp));
         ppp = clamp(ppp + qmul(dt, clamp(p_pv + qmul(dt, p_vv))));
         ppp = clamp(ppp + noise_qp);
         ppv = clamp(p_pv + qmul(dt, p_vv));
         pvp = clamp(p_vp + qmul(dt, p_vv));
         pvv = clamp(p_vv + noise_qv);
         s = clamp(ppp + rn);
         // zero innovation variance leaves both gains at zero
         if (s != 0) begin
            kp = qdiv(ppp, s);
            kv = qdiv(pvp, s);
         end
         e = clamp(z - ppos);
         est_pos = clamp(ppos + qmul(kp, e));
         est_vel = clamp(pvel + qmul(kv, e));
         omk = clamp(QOne - kp);
         p_pp = qmul(ppp, omk);
         p_pv = qmul(ppv, omk);
         p_vp = clamp(pvp - qmul(kv, ppp));
         p_vv = clamp(pvv - qmul(kv, ppv));
      end
      exp_est.pos = est_pos[DataWidth-1:0];
      exp_est.vel = est_vel[DataWidth-1:0];
      estimate_q.push_back(exp_est);
   endtask

   always @(posedge clock) begin
      estimate_t want;
      if (reset) begin
         noise_qp = 66; noise_qv = 655; noise_r = 32768;
         restore_estimate();
         estimate_q.delete();
         fail_count = 0;
         checked = 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CsrQPos:   noise_qp = csr_data;
               CsrQVel:   noise_qv = csr_data;
               CsrRNoise: noise_r  = csr_data;
               default: ;
            endcase
         end
         // results are compared before the new request is predicted
         if (rsp_valid && rsp_ready) begin
            if (estimate_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result pos=%0d vel=%0d", $realtime,
                           rsp_position_est, rsp_velocity_est);
            end else begin
               want = estimate_q.pop_front();
               checked++;
               if (want.pos !== rsp_position_est || want.vel !== rsp_velocity_est) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch pos exp %0d got %0d, vel exp %0d got %0d",
                              $realtime, want.pos, rsp_position_est,
                              want.vel, rsp_velocity_est);
               end
            end
         end
         if (req_valid && req_ready)
            filter_step(req_opcode, longint'(req_measurement), longint'(req_time_step));
      end
      pending = estimate_q.size();
   end
endmodule

>>> bench/tb_kalman_cv_tracker.sv
// tb_kalman_cv_tracker: stimulus and verdict for the tracker regression.
// Depends on kct_pkg, kalman_cv_tracker and kct_checker.
module tb_kalman_cv_tracker;
   import kct_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OpUpdate = 1'b0;
   localparam logic OpReset  = 1'b1;
   localparam int   CycleLimit = 2_000_000;
   localparam logic [CfgWidth-1:0] CfgMax = {CfgWidth{1'b1}};
   localparam int   PhaseLen = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_opcode = OpUpdate;
   logic signed [DataWidth-1:0] req_measurement = '0;
   logic [CfgWidth-1:0] req_time_step = '0;
   logic rsp_ready = 1'b0;
   logic csr_write = 1'b0;
   logic [CsrIdxWidth-1:0] csr_index = CsrQPos;
   logic [CfgWidth-1:0] csr_data = '0;
   logic req_ready, rsp_valid;
   logic signed [DataWidth-1:0] rsp_position_est, rsp_velocity_est;
   int fail_count, pending, checked;
   int sent = 0, resets_sent = 0, settings_used = 0, cycles = 0;
   int burst_left = 0;

   always #1 clock = ~clock;

   kalman_cv_tracker u_dut (.*);

   kct_checker #(.ResetCode(OpReset)) u_checker (.*);

   // receiver stall pattern: free-running, mostly-ready or mostly-stalled stretches
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(2);
         stall_left = $urandom_range(5, 60);
      end else
         stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(3) != 0);
         default: rsp_ready <= ($urandom_range(5) == 0);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // one request, with bursts and random gaps between them
   task automatic send_req(input logic op, input logic signed [DataWidth-1:0] z,
                           input logic [CfgWidth-1:0] dt);
      req_valid <= 1'b1;
      req_opcode <= op;
      req_measurement <= z;
      req_time_step <= dt;
      do @(posedge clock); while (!req_ready);
      sent++;
      if (op == OpReset) resets_sent++;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end else
         burst_left--;
   endtask

   // let the block drain before touching registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_noise(input logic [CfgWidth-1:0] qp, input logic [CfgWidth-1:0] qv,
                             input logic [CfgWidth-1:0] rn);
      wait_idle();
      csr_write <= 1'b1; csr_index <= CsrQPos; csr_data <= qp;
      @(posedge clock);
      csr_index <= CsrQVel; csr_data <= qv;
      @(posedge clock);
      csr_index <= CsrRNoise; csr_data <= rn;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin
      longint trk_pos, trk_vel;
      int pick;
      logic [CfgWidth-1:0] dt;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes of fields, both operations, noise corner cases
      send_req(OpReset, 32'sd0, '0);
      send_req(OpUpdate, 32'sh0001_0000, 31'd65536);
      send_req(OpUpdate, VMax, '0);
      send_req(OpUpdate, VMin, CfgMax);
      send_req(OpUpdate, VMax, CfgMax);
      send_req(OpUpdate, 32'sd0, 31'd1);
      send_req(OpReset, VMin, CfgMax);
      send_req(OpUpdate, -32'sd1, 31'd3277);
      // zero measurement noise acts as the smallest step
      load_noise('0, '0, '0);
      send_req(OpUpdate, 32'sh0000_8000, '0);
      send_req(OpUpdate, 32'sh0000_8000, '0);
      send_req(OpUpdate, VMin, 31'd65536);
      // saturated noise drives the covariance and gain to extremes
      load_noise(CfgMax, CfgMax, CfgMax);
      send_req(OpUpdate, VMax, CfgMax);
      send_req(OpUpdate, VMin, CfgMax);
      send_req(OpUpdate, 32'sd12345, 31'd100);
      load_noise(CfgMax, CfgMax, 31'd1);
      send_req(OpUpdate, VMax, CfgMax);
      send_req(OpUpdate, VMin, 31'd2);
      send_req(OpReset, 32'sd0, '0);

      // random phases over several noise settings
      trk_pos = 0; trk_vel = 65536;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: load_noise(31'd66, 31'd655, 31'd32768);
            1: load_noise(31'd1000, 31'd20, 31'd1 << 20);
            2: load_noise('0, '0, '0);
            3: load_noise(CfgMax, CfgMax, CfgMax);
            default: load_noise(CfgWidth'($urandom), CfgWidth'($urandom_range(1 << 16)),
                                CfgWidth'($urandom));
         endcase
         for (int n = 0; n < PhaseLen; n++) begin
            pick = $urandom_range(99);
            if (pick < 3) begin
               send_req(OpReset, $urandom, CfgWidth'($urandom));
               trk_pos = 0;
            end else if (pick < 12) begin
               send_req(OpUpdate, $urandom, CfgWidth'($urandom));
            end else if (pick < 18) begin
               send_req(OpUpdate, $urandom_range(1) ? VMax : VMin,
                        $urandom_range(1) ? CfgMax : 31'($urandom_range(1)));
            end else begin
               // plausible track with measurement noise
               dt = CfgWidth'($urandom_range(200, 8000));
               if ($urandom_range(15) == 0)
                  trk_vel = longint'($urandom_range(1 << 22)) - (1 << 21);
               trk_pos += (trk_vel * dt) >>> FracBits;
               if (trk_pos > (1 << 29) || trk_pos < -(1 << 29)) trk_pos = 0;
               send_req(OpUpdate,
                        DataWidth'(trk_pos + longint'($urandom_range(1 << 17)) - (1 << 16)),
                        dt);
            end
         end
      end

      // drain and settle
      wait_idle();
      repeat (150) @(posedge clock);
      $display("%0d requests (%0d resets) over %0d noise settings, %0d estimates compared",
               sent, resets_sent, settings_used, checked);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
